FILE: hdl/suth_pkg.sv
// Package for the Sutherland viscosity pipeline.
// Word widths, fixed-point format and pipeline stage counts; no dependencies.
package suth_pkg;

  localparam int unsigned WordW    = 24;                  // Q8.16 word
  localparam int unsigned FracBits = 16;
  localparam int unsigned DenW     = WordW + 1;           // t + c
  localparam int unsigned SqW      = 2 * WordW;           // t^2
  localparam int unsigned PartW    = 2 * WordW;           // half of t^2 times t
  localparam int unsigned CubeW    = 3 * WordW - FracBits; // floor(t^3 / 2^F)
  localparam int unsigned RootW    = CubeW / 2;           // sqrt result
  localparam int unsigned RemW     = RootW + 1;
  localparam int unsigned MulW     = FracBits + 1 > WordW ? FracBits + 1 : DenW;
  localparam int unsigned ProdW    = RootW + MulW;
  localparam int unsigned DivSteps = WordW;
  // entry, t^2, partials, cube, root steps, product, overflow check, quotient steps
  localparam int unsigned NumStg   = 4 + RootW + 2 + DivSteps;

  typedef logic [WordW-1:0] word_t;
  typedef logic [DenW-1:0]  den_t;

endpackage

FILE: hdl/sutherland_viscosity.sv
// Sutherland viscosity law: mu = t^1.5 * (1 + c) / (t + c), unsigned Q8.16.
// Deep pipeline: multiplies, one root bit per stage, one quotient bit per stage.
// Depends on suth_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one temperature per
//   transaction. Output channel (out_valid_o / out_ready_i) returns viscosity_o
//   and out_of_range_o, one transaction per input, in order.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes sutherland_ratio;
//   write it only while the pipeline is empty.
//   Throughput: one item per cycle while the output is not stalled. The
//   pipeline has 58 register stages: 4 multiply/entry stages, 28
//   square-root stages, product and overflow stages and 24 division
//   stages, most of them in the bit-serial root and quotient.
//   Reset clears all valid bits and loads the ratio with 110.4/288.15.
//   When the receiver stalls the whole pipeline holds; in_ready_o drops only
//   while the output register holds an untaken result.
//   Zero denominator gives 0 with out_of_range_o; overflow saturates to
//   0xFFFFFF with out_of_range_o.
module sutherland_viscosity
  import suth_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  word_t       sutherland_ratio_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  word_t       temperature_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output word_t       viscosity_o,
  output logic        out_of_range_o
);

  localparam int unsigned SqrtBase = 4;
  localparam int unsigned DivBase  = SqrtBase + RootW + 2;

  word_t                  ratio_q;
  logic [NumStg-1:0]      vld_q;
  logic                   en;

  assign en          = ~vld_q[NumStg-1] | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= word_t'(25109);
    end else if (cfg_valid_i) begin
      ratio_q <= sutherland_ratio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStg-2:0], in_valid_i};
    end
  end

  // den and zero flag travel with every stage
  den_t  den_q [NumStg];
  logic  dz_q  [NumStg];

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0] <= DenW'(temperature_i) + DenW'(ratio_q);
      dz_q[0]  <= (temperature_i == '0) && (ratio_q == '0);
      for (int i = 1; i < NumStg; i++) begin
        den_q[i] <= den_q[i-1];
        dz_q[i]  <= dz_q[i-1];
      end
    end
  end

  // t^3 in three stages
  word_t               t0_q, t1_q;
  logic [SqW-1:0]      t2_q;
  logic [PartW-1:0]    plo_q, phi_q;
  logic [CubeW-1:0]    cube_q;
  logic [3*WordW-1:0]  cube_full;

  assign cube_full = {phi_q, WordW'(0)} + (3*WordW)'(plo_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q   <= temperature_i;
      t1_q   <= t0_q;
      t2_q   <= SqW'(t0_q) * SqW'(t0_q);
      plo_q  <= PartW'(t2_q[WordW-1:0]) * PartW'(t1_q);
      phi_q  <= PartW'(t2_q[SqW-1:WordW]) * PartW'(t1_q);
      cube_q <= cube_full[3*WordW-1:FracBits];
    end
  end

  // square root, one result bit per stage
  logic [CubeW-1:0] sx_q   [RootW];
  logic [RemW-1:0]  srem_q [RootW];
  logic [RootW-1:0] sroot_q[RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_sqrt
    logic [CubeW-1:0] x_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [RemW+1:0]  r2, trial;
    if (k == 0) begin : g_first
      assign x_in    = cube_q;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign x_in    = sx_q[k-1];
      assign rem_in  = srem_q[k-1];
      assign root_in = sroot_q[k-1];
    end
    assign r2    = {rem_in, x_in[2*(RootW-1-k)+1 -: 2]};
    assign trial = (RemW+2)'({root_in, 2'b01});
    always_ff @(posedge clk_i) begin
      if (en) begin
        sx_q[k] <= x_in;
        if (r2 >= trial) begin
          srem_q[k]  <= RemW'(r2 - trial);
          sroot_q[k] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          srem_q[k]  <= RemW'(r2);
          sroot_q[k] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  // s * (2^F + c), then overflow test against den * 2^24
  logic [ProdW-1:0] prod_q;
  logic [MulW-1:0]  mul_m;
  assign mul_m = MulW'(1) << FracBits;

  den_t              dr_q  [DivSteps+1];
  logic [WordW-1:0]  dlo_q [DivSteps+1];
  logic [WordW-1:0]  dq_q  [DivSteps+1];
  logic              ovf_q [DivSteps+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= ProdW'(sroot_q[RootW-1]) * ProdW'(mul_m + MulW'(ratio_q));
      ovf_q[0] <= ProdW'(prod_q[ProdW-1:WordW]) >= ProdW'(den_q[DivBase-2]);
      dr_q[0]  <= DenW'(prod_q[ProdW-1:WordW]);
      dlo_q[0] <= prod_q[WordW-1:0];
      dq_q[0]  <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j <= DivSteps; j++) begin : g_div
    logic [DenW:0] r2;
    logic [DenW:0] dd;
    assign r2 = {dr_q[j-1], dlo_q[j-1][WordW-j]};
    assign dd = (DenW+1)'(den_q[DivBase+j-2]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        dlo_q[j] <= dlo_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        if (r2 >= dd) begin
          dr_q[j] <= DenW'(r2 - dd);
          dq_q[j] <= {dq_q[j-1][WordW-2:0], 1'b1};
        end else begin
          dr_q[j] <= DenW'(r2);
          dq_q[j] <= {dq_q[j-1][WordW-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (dz_q[NumStg-1]) begin
      viscosity_o    = '0;
      out_of_range_o = 1'b1;
    end else if (ovf_q[DivSteps]) begin
      viscosity_o    = '1;
      out_of_range_o = 1'b1;
    end else begin
      viscosity_o    = dq_q[DivSteps];
      out_of_range_o = 1'b0;
    end
  end

endmodule
